/* src/vrf_pkg.sv */
// Shared constants and types of the VARMA residual filter.
`default_nettype none
package vrf_pkg;
	localparam int DIM_MAX      = 4;
	localparam int AR_MAX       = 4;
	localparam int MA_MAX       = 4;
	localparam int SAMPLE_WIDTH = 20;
	localparam int COEF_WIDTH   = 16;
	localparam int COEF_FRAC    = COEF_WIDTH - 4;
	localparam int CFG_W        = 3;
	localparam int CIDX_W       = 2;
	localparam int IDX_W        = 2;
	localparam int ADDR_W       = 7;
	localparam int STORE_DEPTH  = 128;
	localparam int PROD_W       = SAMPLE_WIDTH + COEF_WIDTH;
	localparam int ACC_W        = PROD_W + $clog2((AR_MAX + MA_MAX) * DIM_MAX) + 2;
	localparam int SEEN_W       = 3;

	localparam logic [CIDX_W-1:0] REG_DIM = 2'd0;
	localparam logic [CIDX_W-1:0] REG_AR  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_MA  = 2'd2;

	localparam logic FUNC_COEF   = 1'b0;
	localparam logic FUNC_SAMPLE = 1'b1;

	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_HI = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_LO = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEF_WIDTH-1:0] coef_t;

	typedef struct packed {
		logic             load;
		logic             start;
		logic             row_init;
		logic             term_vld;
		logic             term_ar;
		logic [IDX_W-1:0] term_k;
		logic [IDX_W-1:0] term_c;
		logic [IDX_W-1:0] row;
		logic             row_store;
		logic             finish;
	} cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] dim;
		logic [CFG_W-1:0] p;
		logic [CFG_W-1:0] q;
		logic             pass;
	} sts_t;
endpackage
`default_nettype wire

/* src/varma_residual_filter.sv */
// Top level of the VARMA residual filter.
//
//   channel | signals                                  | role
//   in      | in_valid/in_ready, func..x3              | coefficient write or sample
//   out     | out_valid/out_ready, resid0..3, clipped  | residual vector
//   cfg     | cfg_we, cfg_index, cfg_data              | dim_in_use, ar_order, ma_order
//
// A sample that passes through goes straight to its result; otherwise each row
// runs its terms through one shared multiply-accumulate, one term a cycle, then
// a row tail of S_DRAIN1, S_DRAIN2 and S_STORE (a row goes from init straight
// to store when p and q are both zero).
// Reset sets config to dim 4, p 1, q 0 and clears histories and the sample count; coefficients stay undefined.
// A waiting result holds the last step of the next sample until out_ready;
// coefficient writes and that next sample are taken while the controller is idle.
`default_nettype none
module varma_residual_filter (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          func,
	input  wire logic [vrf_pkg::ADDR_W-1:0]    coef_index,
	input  wire logic signed [vrf_pkg::COEF_WIDTH-1:0]   coef_value,
	input  wire logic                          first_of_series,
	input  wire logic signed [vrf_pkg::SAMPLE_WIDTH-1:0] x0,
	input  wire logic signed [vrf_pkg::SAMPLE_WIDTH-1:0] x1,
	input  wire logic signed [vrf_pkg::SAMPLE_WIDTH-1:0] x2,
	input  wire logic signed [vrf_pkg::SAMPLE_WIDTH-1:0] x3,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [vrf_pkg::SAMPLE_WIDTH-1:0] resid0,
	output logic signed [vrf_pkg::SAMPLE_WIDTH-1:0] resid1,
	output logic signed [vrf_pkg::SAMPLE_WIDTH-1:0] resid2,
	output logic signed [vrf_pkg::SAMPLE_WIDTH-1:0] resid3,
	output logic                               clipped,
	input  wire logic                          cfg_we,
	input  wire logic [vrf_pkg::CIDX_W-1:0]    cfg_index,
	input  wire logic [vrf_pkg::CFG_W-1:0]     cfg_data
);
	import vrf_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	sample_t           xin  [DIM_MAX];
	sample_t           resid[DIM_MAX];
	logic [COEF_WIDTH-1:0] rdata;
	logic              coef_we;
	logic [ADDR_W-1:0] raddr;

	assign xin[0] = x0;
	assign xin[1] = x1;
	assign xin[2] = x2;
	assign xin[3] = x3;
	assign resid0 = resid[0];
	assign resid1 = resid[1];
	assign resid2 = resid[2];
	assign resid3 = resid[3];

	assign coef_we = in_valid && in_ready && (func == FUNC_COEF);
	// kind is 0 for AR, 1 for MA
	assign raddr   = {~cmd.term_ar, cmd.term_k, cmd.row, cmd.term_c};

	vrf_ram #(.WIDTH(COEF_WIDTH), .DEPTH(STORE_DEPTH)) u_coef (
		.clk   (clk),
		.we    (coef_we),
		.waddr (coef_index),
		.wdata (coef_value),
		.raddr (raddr),
		.rdata (rdata)
	);

	vrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_func   (func),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	vrf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.first_of_series (first_of_series),
		.xin             (xin),
		.coef_rdata      (coef_t'(rdata)),
		.cmd             (cmd),
		.sts             (sts),
		.resid           (resid),
		.clipped         (clipped)
	);

	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && func == FUNC_SAMPLE) |=> !in_ready)
		else $error("sample item accepted but block stayed ready");

	a_clip_has_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && clipped) |->
		(resid0 == SAMPLE_HI || resid0 == SAMPLE_LO || resid1 == SAMPLE_HI ||
		 resid1 == SAMPLE_LO || resid2 == SAMPLE_HI || resid2 == SAMPLE_LO ||
		 resid3 == SAMPLE_HI || resid3 == SAMPLE_LO))
		else $error("clipped set with no channel at a rail");

	a_one_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("result finished but not presented");
endmodule
`default_nettype wire

/* src/vrf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vrf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* src/vrf_ctrl.sv */
// Sequencer: walks rows and coefficient terms for one sample item.
`default_nettype none
module vrf_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_func,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire vrf_pkg::sts_t sts,
	output vrf_pkg::cmd_t      cmd
);
	import vrf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_ROW_INIT, S_TERM, S_DRAIN1, S_DRAIN2, S_STORE, S_FINISH
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] row_q, k_q, c_q;
	logic             ar_q;
	logic             c_last, k_last, row_last;

	assign in_ready = (state_q == S_IDLE);
	assign c_last   = ((CFG_W'(c_q) + CFG_W'(1)) == sts.dim);
	assign k_last   = ((CFG_W'(k_q) + CFG_W'(1)) == (ar_q ? sts.p : sts.q));
	assign row_last = ((CFG_W'(row_q) + CFG_W'(1)) == sts.dim);

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready && (in_func == FUNC_SAMPLE);
		cmd.start     = (state_q == S_CHECK);
		cmd.row_init  = (state_q == S_ROW_INIT);
		cmd.term_vld  = (state_q == S_TERM);
		cmd.term_ar   = ar_q;
		cmd.term_k    = k_q;
		cmd.term_c    = c_q;
		cmd.row       = row_q;
		cmd.row_store = (state_q == S_STORE);
		cmd.finish    = (state_q == S_FINISH) && (!out_valid || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
			row_q     <= '0;
			k_q       <= '0;
			c_q       <= '0;
			ar_q      <= 1'b1;
		end else begin
			if (cmd.finish) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					row_q   <= '0;
					state_q <= sts.pass ? S_FINISH : S_ROW_INIT;
				end
				S_ROW_INIT: begin
					k_q <= '0;
					c_q <= '0;
					if (sts.p != '0) begin
						ar_q    <= 1'b1;
						state_q <= S_TERM;
					end else if (sts.q != '0) begin
						ar_q    <= 1'b0;
						state_q <= S_TERM;
					end else begin
						state_q <= S_STORE;
					end
				end
				S_TERM: begin
					if (!c_last) begin
						c_q <= c_q + IDX_W'(1);
					end else begin
						c_q <= '0;
						if (!k_last) begin
							k_q <= k_q + IDX_W'(1);
						end else if (ar_q && sts.q != '0) begin
							k_q  <= '0;
							ar_q <= 1'b0;
						end else begin
							state_q <= S_DRAIN1;
						end
					end
				end
				S_DRAIN1: state_q <= S_DRAIN2;
				S_DRAIN2: state_q <= S_STORE;
				S_STORE: begin
					if (row_last) begin
						state_q <= S_FINISH;
					end else begin
						row_q   <= row_q + IDX_W'(1);
						state_q <= S_ROW_INIT;
					end
				end
				S_FINISH: begin
					// hold until the output register is free
					if (cmd.finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/vrf_dp.sv */
// Datapath: config, histories, shared multiply-accumulate, round and clip.
`default_nettype none
module vrf_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [vrf_pkg::CIDX_W-1:0]           cfg_index,
	input  wire logic [vrf_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic                                 first_of_series,
	input  wire vrf_pkg::sample_t                     xin [vrf_pkg::DIM_MAX],
	input  wire vrf_pkg::coef_t                       coef_rdata,
	input  wire vrf_pkg::cmd_t                        cmd,
	output vrf_pkg::sts_t                             sts,
	output vrf_pkg::sample_t                          resid [vrf_pkg::DIM_MAX],
	output logic                                      clipped
);
	import vrf_pkg::*;

	logic [CFG_W-1:0]  dim_q, ar_q, ma_q;
	logic [CFG_W-1:0]  dim, p, q, pq;
	logic [SEEN_W-1:0] seen_q;
	sample_t           x_q  [DIM_MAX];
	sample_t           res_q[DIM_MAX];
	sample_t           sh_q [AR_MAX][DIM_MAX];
	sample_t           rh_q [MA_MAX][DIM_MAX];
	sample_t           op_s1;
	logic              vld_s1, ar_s1, vld_s2, ar_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q, acc_rnd, y;
	logic              ovf, clip_q;
	sample_t           y_sat;

	always_comb begin
		if (dim_q == '0) begin
			dim = CFG_W'(1);
		end else if (dim_q > CFG_W'(DIM_MAX)) begin
			dim = CFG_W'(DIM_MAX);
		end else begin
			dim = dim_q;
		end
		p  = (ar_q > CFG_W'(AR_MAX)) ? CFG_W'(AR_MAX) : ar_q;
		q  = (ma_q > CFG_W'(MA_MAX)) ? CFG_W'(MA_MAX) : ma_q;
		pq = (p > q) ? p : q;
	end

	assign sts.dim  = dim;
	assign sts.p    = p;
	assign sts.q    = q;
	assign sts.pass = (SEEN_W'(pq) > seen_q);

	// round half up, then clip to the sample range
	assign acc_rnd = acc_q + (ACC_W'(1) <<< (COEF_FRAC - 1));
	assign y       = acc_rnd >>> COEF_FRAC;
	assign ovf     = (y > ACC_W'(SAMPLE_HI)) || (y < ACC_W'(SAMPLE_LO));
	assign y_sat   = (y > ACC_W'(SAMPLE_HI)) ? SAMPLE_HI :
	                 (y < ACC_W'(SAMPLE_LO)) ? SAMPLE_LO : SAMPLE_WIDTH'(y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q  <= CFG_W'(4);
			ar_q   <= CFG_W'(1);
			ma_q   <= CFG_W'(0);
			seen_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int i = 0; i < AR_MAX; i++) begin
				for (int c = 0; c < DIM_MAX; c++) sh_q[i][c] <= '0;
			end
			for (int i = 0; i < MA_MAX; i++) begin
				for (int c = 0; c < DIM_MAX; c++) rh_q[i][c] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DIM: dim_q <= cfg_data;
					REG_AR:  ar_q  <= cfg_data;
					REG_MA:  ma_q  <= cfg_data;
					default: ;
				endcase
			end
			vld_s1 <= cmd.term_vld;
			vld_s2 <= vld_s1;
			if (cmd.load && first_of_series) begin
				seen_q <= '0;
				for (int i = 0; i < AR_MAX; i++) begin
					for (int c = 0; c < DIM_MAX; c++) sh_q[i][c] <= '0;
				end
				for (int i = 0; i < MA_MAX; i++) begin
					for (int c = 0; c < DIM_MAX; c++) rh_q[i][c] <= '0;
				end
			end
			if (cmd.finish) begin
				for (int i = AR_MAX - 1; i > 0; i--) sh_q[i] <= sh_q[i-1];
				sh_q[0] <= x_q;
				for (int i = MA_MAX - 1; i > 0; i--) rh_q[i] <= rh_q[i-1];
				rh_q[0] <= res_q;
				if (seen_q != '1) begin
					seen_q <= seen_q + SEEN_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int c = 0; c < DIM_MAX; c++) begin
				x_q[c] <= (CFG_W'(c) < dim) ? xin[c] : '0;
			end
		end
		if (cmd.start) begin
			clip_q <= 1'b0;
			for (int c = 0; c < DIM_MAX; c++) res_q[c] <= sts.pass ? x_q[c] : '0;
		end
		// stage 1: coefficient read, history operand
		op_s1 <= cmd.term_ar ? sh_q[cmd.term_k][cmd.term_c] : rh_q[cmd.term_k][cmd.term_c];
		ar_s1 <= cmd.term_ar;
		// stage 2: product
		prod_s2 <= coef_rdata * op_s1;
		ar_s2   <= ar_s1;
		if (cmd.row_init) begin
			acc_q <= ACC_W'(x_q[cmd.row]) <<< COEF_FRAC;
		end else if (vld_s2) begin
			acc_q <= ar_s2 ? acc_q - ACC_W'(prod_s2) : acc_q + ACC_W'(prod_s2);
		end
		if (cmd.row_store) begin
			res_q[cmd.row] <= y_sat;
			clip_q         <= clip_q | ovf;
		end
		if (cmd.finish) begin
			resid   <= res_q;
			clipped <= clip_q;
		end
	end
endmodule
`default_nettype wire
